// File: src/utm_pkg.sv
// Package for the URI tail matcher: phase and verdict codes, character constants,
// the URI character bit sets and the context and item structs.
// No dependencies.
package utm_pkg;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_COLON  = 4'd1,
		PH_SLASH1 = 4'd2,
		PH_SLASH2 = 4'd3,
		PH_USER   = 4'd4,
		PH_HOST   = 4'd5,
		PH_PORT   = 4'd6,
		PH_PATH   = 4'd7,
		PH_QUERY  = 4'd8,
		PH_FRAG   = 4'd9,
		PH_HEX1   = 4'd10,
		PH_HEX2   = 4'd11,
		PH_FILE   = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		V_GROUND = 2'd0,
		V_MORE   = 2'd1,
		V_MAY    = 2'd2,
		V_DONE   = 2'd3
	} verdict_t;

	typedef enum logic {
		CMD_BEGIN = 1'b0,
		CMD_CHAR  = 1'b1
	} command_t;

	localparam int URI_LEN_W  = 12;
	localparam int SCHEME_W   = 12;

	localparam logic [7:0] CH_LOW     = 8'h21;
	localparam logic [7:0] CH_HIGH    = 8'h7E;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_PERCENT = 8'h25;

	// Allowed URI characters for bytes 0x20..0x7F, one word per block of 32 codes.
	localparam logic [2:0][31:0] URI_CHARS = {32'h47FFFFFE, 32'h87FFFFFF, 32'hAFFFFC42};

	typedef struct packed {
		phase_t   phase;
		phase_t   saved;
		verdict_t last;
		logic     is_file;
	} utm_ctx_t;

	typedef struct packed {
		command_t            command;
		logic [7:0]          ch;
		logic [SCHEME_W-1:0] scheme_len;
		logic                file_scheme;
	} utm_item_t;

endpackage

// File: src/utm_step.sv
// Next-state and result logic of the URI tail matcher for one beat.
// Purely combinational; depends on utm_pkg.
module utm_step import utm_pkg::*; #(
	parameter int MAX_URI_LEN = 4095
) (
	input  utm_item_t                                item,
	input  utm_ctx_t                                 ctx,
	input  logic [$clog2(MAX_URI_LEN+1)-1:0]         count,
	output utm_ctx_t                                 ctx_next,
	output logic [$clog2(MAX_URI_LEN+1)-1:0]         count_next,
	output verdict_t                                 verdict,
	output logic [URI_LEN_W-1:0]                     uri_len
);

	localparam int LEN_W  = $clog2(MAX_URI_LEN + 1);
	localparam int WIDE_W = (LEN_W > SCHEME_W) ? LEN_W : SCHEME_W;

	logic [7:0]        c;
	logic              in_range;
	logic              in_set;
	logic              is_digit;
	logic              is_hex;
	logic [1:0]        word_sel;
	logic [4:0]        bit_sel;
	verdict_t          adv_v;
	phase_t            adv_phase;
	phase_t            adv_saved;
	logic [WIDE_W-1:0] sl_wide;
	logic [WIDE_W-1:0] max_wide;
	logic [WIDE_W-1:0] len_wide;

	assign c        = item.ch;
	assign in_range = (c >= CH_LOW) && (c <= CH_HIGH);
	assign word_sel = 2'(c[7:5] - 3'd1);
	assign bit_sel  = c[4:0];
	assign in_set   = (word_sel != 2'd3) && URI_CHARS[word_sel][bit_sel];
	assign is_digit = c inside {[8'h30:8'h39]};
	assign is_hex   = c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};

	// Phase walk for one byte; V_GROUND here means the byte is rejected.
	always_comb begin
		adv_v     = V_GROUND;
		adv_phase = ctx.phase;
		adv_saved = ctx.saved;
		case (ctx.phase)
			PH_COLON: begin
				if (c == CH_COLON) begin
					adv_phase = PH_SLASH1;
					adv_v     = V_MORE;
				end
			end
			PH_SLASH1: begin
				if (c == CH_SLASH) begin
					adv_phase = PH_SLASH2;
					adv_v     = V_MORE;
				end
			end
			PH_SLASH2: begin
				if (c == CH_SLASH) begin
					adv_phase = ctx.is_file ? PH_FILE : PH_USER;
					adv_v     = V_MORE;
				end
			end
			PH_USER, PH_HOST, PH_PATH, PH_QUERY, PH_FRAG: begin
				if (ctx.phase == PH_USER && c == CH_AT) begin
					adv_phase = PH_HOST;
					adv_v     = V_MORE;
				end else if ((ctx.phase == PH_USER || ctx.phase == PH_HOST)
						&& c == CH_COLON) begin
					adv_phase = PH_PORT;
					adv_v     = V_MORE;
				end else if (ctx.phase != PH_QUERY && ctx.phase != PH_FRAG
						&& c == CH_SLASH) begin
					adv_phase = PH_PATH;
					adv_v     = V_MAY;
				end else if (ctx.phase != PH_QUERY && ctx.phase != PH_FRAG
						&& c == CH_QUEST) begin
					adv_phase = PH_QUERY;
					adv_v     = V_MAY;
				end else if (ctx.phase != PH_FRAG && c == CH_HASH) begin
					adv_phase = PH_FRAG;
					adv_v     = V_MAY;
				end else if (c == CH_PERCENT) begin
					adv_saved = ctx.phase;
					adv_phase = PH_HEX1;
					adv_v     = V_MORE;
				end else if (in_set) begin
					adv_v = V_MAY;
				end
			end
			PH_PORT: begin
				if (c == CH_SLASH) begin
					adv_phase = PH_PATH;
					adv_v     = V_MAY;
				end else if (c == CH_QUEST) begin
					adv_phase = PH_QUERY;
					adv_v     = V_MAY;
				end else if (c == CH_HASH) begin
					adv_phase = PH_FRAG;
					adv_v     = V_MAY;
				end else if (is_digit) begin
					adv_v = V_MAY;
				end
			end
			PH_HEX1: begin
				if (is_hex) begin
					adv_phase = PH_HEX2;
					adv_v     = V_MORE;
				end
			end
			PH_HEX2: begin
				if (is_hex) begin
					adv_phase = ctx.saved;
					adv_v     = V_MAY;
				end
			end
			PH_FILE: begin
				adv_v = V_MAY;
			end
			default: begin
				adv_v = V_GROUND;
			end
		endcase
	end

	assign sl_wide  = WIDE_W'(item.scheme_len);
	assign max_wide = WIDE_W'(MAX_URI_LEN);

	always_comb begin
		ctx_next   = ctx;
		count_next = count;
		verdict    = V_GROUND;
		if (item.command == CMD_BEGIN) begin
			count_next       = (sl_wide > max_wide) ? LEN_W'(max_wide) : LEN_W'(sl_wide);
			ctx_next.is_file = item.file_scheme;
			ctx_next.phase   = PH_COLON;
			verdict          = V_MORE;
		end else if (ctx.phase == PH_IDLE) begin
			count_next = '0;
			verdict    = V_GROUND;
		end else if (in_range && adv_v != V_GROUND) begin
			ctx_next.phase = adv_phase;
			ctx_next.saved = adv_saved;
			verdict        = adv_v;
			if (WIDE_W'(count) < max_wide) begin
				count_next = LEN_W'(count + 1'b1);
			end
		end else begin
			ctx_next.phase = PH_IDLE;
			if (ctx.last == V_MAY) begin
				verdict = V_DONE;
			end else begin
				count_next = '0;
				verdict    = V_GROUND;
			end
		end
		ctx_next.last = verdict;
	end

	assign len_wide = WIDE_W'(count_next);
	assign uri_len  = len_wide[URI_LEN_W-1:0];

endmodule

// File: src/uri_tail_matcher_top.sv
// URI tail matcher: beats wait in the input stage, results in the output register.
// Throughput one beat per cycle unless a waiting result stalls: the phase update is a
// single pass fed back from the context register, so beats flow while results drain.
// Asynchronous active-low reset clears the context to the idle phase, the length to
// zero and empties both the input stage and the output register.
// Depends on utm_pkg and utm_step.
module uri_tail_matcher_top import utm_pkg::*; #(
	parameter int MAX_URI_LEN = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // ch [7:0], scheme_len [19:8], file_scheme [20], zero pad
	input  logic        s_tuser,   // command: 0 begins a candidate, 1 presents a character
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // verdict [1:0], uri_len [13:2], zero pad
);

	localparam int LEN_W = $clog2(MAX_URI_LEN + 1);

	// Input stage: one registered beat waiting to be stepped.
	logic       valid_s1;
	utm_item_t  item_s1;

	// Recogniser context and accepted length.
	utm_ctx_t          ctx_q;
	logic [LEN_W-1:0]  count_q;

	utm_ctx_t          ctx_next;
	logic [LEN_W-1:0]  count_next;
	verdict_t          verdict;
	logic [URI_LEN_W-1:0] uri_len;

	logic step_go;

	// The staged beat is processed whenever the output register is free or is being
	// emptied this cycle, so a waiting result never holds back the input side for more
	// than the one slot of the input stage.
	assign step_go  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command     <= command_t'(s_tuser);
			item_s1.ch          <= s_tdata[7:0];
			item_s1.scheme_len  <= s_tdata[19:8];
			item_s1.file_scheme <= s_tdata[20];
		end
	end

	utm_step #(
		.MAX_URI_LEN(MAX_URI_LEN)
	) u_step (
		.item       (item_s1),
		.ctx        (ctx_q),
		.count      (count_q),
		.ctx_next   (ctx_next),
		.count_next (count_next),
		.verdict    (verdict),
		.uri_len    (uri_len)
	);

	// Context only moves when a beat is actually stepped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.phase   <= PH_IDLE;
			ctx_q.saved   <= PH_IDLE;
			ctx_q.last    <= V_GROUND;
			ctx_q.is_file <= 1'b0;
			count_q       <= '0;
		end else if (step_go) begin
			ctx_q   <= ctx_next;
			count_q <= count_next;
		end
	end

	// Output register: holds a finished result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (step_go) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			m_tdata <= {2'b00, uri_len, verdict};
		end
	end

endmodule
